[design/polygon_segment_crossing_test_top_macros.svh]
// ----------------------------------------------------------------------------
// Polygon segment crossing test assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POLYGON_SEGMENT_CROSSING_TEST_TOP_MACROS_SVH
`define POLYGON_SEGMENT_CROSSING_TEST_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/psct_pkg.sv]
// ----------------------------------------------------------------------------
// Polygon segment crossing test package
// Sizes, stored vertex type, command codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psct_pkg;

    localparam int MAX_VERTS    = 32;
    localparam int COORD_BITS   = 16;
    localparam int IDX_W        = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTS + 1);
    localparam int EDGE_W       = 5;
    localparam int RESULT_LIMIT = 32;
    localparam int HCNT_W       = $clog2(RESULT_LIMIT + 1);
    localparam int D_W          = COORD_BITS + 1;
    localparam int P_W          = 2 * D_W;
    localparam int S_W          = P_W + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } vert_t;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEST   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

[design/polygon_segment_crossing_test_top.sv]
// ----------------------------------------------------------------------------
// Polygon segment crossing test
// Stores one closed polygon and reports every edge a test segment crosses.
// ----------------------------------------------------------------------------
// A clear or append item gives one result item. In a test item the vertex
// memory has one read port and the walk reads one vertex per cycle while the
// result side does not stall, then one more step closes the polygon, a
// four-stage edge pipeline drains, the drain state waits for the pipeline
// to empty and the finish state emits the final item. Each crossed
// edge gives one item, in edge order, and the final item carries last; a
// test with no crossing gives a single no-hit item.
// Backpressure on the result side holds the whole edge pipeline.
`timescale 1ns / 1ps

module polygon_segment_crossing_test_top
    import psct_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   cmd,
    input  logic signed [COORD_BITS-1:0] seg_x0,
    input  logic signed [COORD_BITS-1:0] seg_y0,
    input  logic signed [COORD_BITS-1:0] seg_x1,
    input  logic signed [COORD_BITS-1:0] seg_y1,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic                         hit,
    output logic [EDGE_W-1:0]            edge_index,
    output logic                         last
);

    function automatic logic opposite(input logic signed [S_W-1:0] a,
                                      input logic signed [S_W-1:0] b);
        logic nz;
        nz = (a != '0) && (b != '0);
        return nz && (a[S_W-1] != b[S_W-1]);
    endfunction

    state_t state_reg, state_next;
    logic [CNT_W-1:0] vcount_reg;
    logic [CNT_W-1:0] issue_reg;

    vert_t vert_mem [MAX_VERTS];
    vert_t rd_data_reg;

    logic signed [COORD_BITS-1:0] bx0_reg, by0_reg;
    logic signed [COORD_BITS-1:0] bxmin_reg, bxmax_reg, bymin_reg, bymax_reg;
    logic signed [D_W-1:0] dbx_reg, dby_reg;

    logic tok_valid_reg, tok_close_reg;
    logic [IDX_W-1:0] tok_k_reg;
    vert_t v0_reg, prev_reg;

    logic e_valid_reg, e_box_reg;
    logic [IDX_W-1:0] e_idx_reg;
    logic signed [D_W-1:0] e_dax_reg, e_day_reg;
    logic signed [D_W-1:0] e_qx0_reg, e_qy0_reg, e_qx1_reg, e_qy1_reg;
    logic signed [D_W-1:0] e_rx0_reg, e_ry0_reg, e_rx1_reg, e_ry1_reg;

    logic m_valid_reg, m_box_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic signed [P_W-1:0] m_p1a_reg, m_p1b_reg, m_p2a_reg, m_p2b_reg;
    logic signed [P_W-1:0] m_p3a_reg, m_p3b_reg, m_p4a_reg, m_p4b_reg;

    logic h_valid_reg, h_hit_reg;
    logic [IDX_W-1:0] h_idx_reg;

    logic pend_valid_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [HCNT_W-1:0] hit_cnt_reg;

    logic out_valid_reg, out_status_reg, out_hit_reg, out_last_reg;
    logic [EDGE_W-1:0] out_idx_reg;
    logic out_status_next, out_hit_next, out_last_next;
    logic [EDGE_W-1:0] out_idx_next;

    logic out_free, adv, in_acc, issuing, pipe_empty, store_full;
    logic edge_go, first_tok, take_hit, emit_pend, finish_go, out_load;
    vert_t cur;
    logic [IDX_W-1:0] edge_idx;
    logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1;
    logic signed [COORD_BITS-1:0] axmin, axmax, aymin, aymax;
    logic box_ok;
    logic signed [S_W-1:0] s1, s2, s3, s4;

    assign out_free   = !out_valid_reg || !out_stall;
    assign adv        = out_free;
    assign in_stall   = (state_reg != ST_IDLE) || !out_free;
    assign in_acc     = in_valid && !in_stall;
    assign issuing    = (state_reg == ST_WALK) && (issue_reg < vcount_reg);
    assign pipe_empty = !(tok_valid_reg || e_valid_reg || m_valid_reg || h_valid_reg);
    assign store_full = (vcount_reg >= CNT_W'(MAX_VERTS));

    // Edge stage: pair the previous vertex with the one just read, or with the first vertex to close the polygon.
    assign cur       = tok_close_reg ? v0_reg : rd_data_reg;
    assign first_tok = tok_valid_reg && !tok_close_reg && (tok_k_reg == '0);
    assign edge_go   = tok_valid_reg && !first_tok;
    assign edge_idx  = tok_close_reg ? IDX_W'(vcount_reg - CNT_W'(1))
                                     : (tok_k_reg - IDX_W'(1));
    assign ax0 = prev_reg.x;
    assign ay0 = prev_reg.y;
    assign ax1 = cur.x;
    assign ay1 = cur.y;
    assign axmin = (ax0 < ax1) ? ax0 : ax1;
    assign axmax = (ax0 < ax1) ? ax1 : ax0;
    assign aymin = (ay0 < ay1) ? ay0 : ay1;
    assign aymax = (ay0 < ay1) ? ay1 : ay0;
    assign box_ok = !((bxmin_reg > axmax) || (bxmax_reg < axmin) ||
                      (bymin_reg > aymax) || (bymax_reg < aymin));

    // Side values; only their signs matter.
    assign s1 = S_W'(m_p1a_reg) - S_W'(m_p1b_reg);
    assign s2 = S_W'(m_p2a_reg) - S_W'(m_p2b_reg);
    assign s3 = S_W'(m_p3a_reg) - S_W'(m_p3b_reg);
    assign s4 = S_W'(m_p4a_reg) - S_W'(m_p4b_reg);

    assign take_hit  = adv && h_valid_reg && h_hit_reg &&
                       (hit_cnt_reg < HCNT_W'(RESULT_LIMIT));
    assign emit_pend = take_hit && pend_valid_reg;
    assign finish_go = (state_reg == ST_FINISH) && out_free;
    assign out_load  = (in_acc && (cmd != CMD_TEST)) || emit_pend || finish_go;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (cmd == CMD_TEST))
                begin
                    state_next = (vcount_reg == '0) ? ST_DRAIN : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (adv && !issuing)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_status_next = 1'b0;
        out_hit_next    = 1'b0;
        out_idx_next    = '0;
        out_last_next   = 1'b1;
        if (emit_pend)
        begin
            out_hit_next  = 1'b1;
            out_idx_next  = EDGE_W'(pend_idx_reg);
            out_last_next = 1'b0;
        end
        else if (finish_go)
        begin
            out_hit_next = pend_valid_reg;
            out_idx_next = pend_valid_reg ? EDGE_W'(pend_idx_reg) : '0;
        end
        else if (cmd == CMD_APPEND)
        begin
            out_status_next = store_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vcount_reg     <= '0;
            issue_reg      <= '0;
            tok_valid_reg  <= 1'b0;
            e_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            h_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            hit_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                issue_reg <= '0;
                if (cmd == CMD_CLEAR)
                begin
                    vcount_reg <= '0;
                end
                else if ((cmd == CMD_APPEND) && !store_full)
                begin
                    vcount_reg <= vcount_reg + CNT_W'(1);
                end
            end
            if (adv)
            begin
                tok_valid_reg <= (state_reg == ST_WALK);
                e_valid_reg   <= edge_go;
                m_valid_reg   <= e_valid_reg;
                h_valid_reg   <= m_valid_reg;
                if (issuing)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
            end
            if (take_hit)
            begin
                pend_valid_reg <= 1'b1;
                hit_cnt_reg    <= hit_cnt_reg + HCNT_W'(1);
            end
            else if (finish_go)
            begin
                pend_valid_reg <= 1'b0;
                hit_cnt_reg    <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Vertex memory: one write port for append, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_acc && (cmd == CMD_APPEND) && !store_full)
        begin
            vert_mem[vcount_reg[IDX_W-1:0]] <= '{x: seg_x0, y: seg_y0};
        end
        if (adv && issuing)
        begin
            rd_data_reg <= vert_mem[issue_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (cmd == CMD_TEST))
        begin
            bx0_reg   <= seg_x0;
            by0_reg   <= seg_y0;
            dbx_reg   <= D_W'(seg_x1) - D_W'(seg_x0);
            dby_reg   <= D_W'(seg_y1) - D_W'(seg_y0);
            bxmin_reg <= (seg_x0 < seg_x1) ? seg_x0 : seg_x1;
            bxmax_reg <= (seg_x0 < seg_x1) ? seg_x1 : seg_x0;
            bymin_reg <= (seg_y0 < seg_y1) ? seg_y0 : seg_y1;
            bymax_reg <= (seg_y0 < seg_y1) ? seg_y1 : seg_y0;
        end
        if (adv)
        begin
            tok_close_reg <= !issuing;
            tok_k_reg     <= issue_reg[IDX_W-1:0];
            if (tok_valid_reg)
            begin
                prev_reg <= cur;
            end
            if (first_tok)
            begin
                v0_reg <= cur;
            end
            e_idx_reg <= edge_idx;
            e_box_reg <= box_ok;
            e_dax_reg <= D_W'(ax1) - D_W'(ax0);
            e_day_reg <= D_W'(ay1) - D_W'(ay0);
            e_qx0_reg <= D_W'(bx0_reg) - D_W'(ax0);
            e_qy0_reg <= D_W'(by0_reg) - D_W'(ay0);
            e_qx1_reg <= (D_W'(bx0_reg) + dbx_reg) - D_W'(ax0);
            e_qy1_reg <= (D_W'(by0_reg) + dby_reg) - D_W'(ay0);
            e_rx0_reg <= D_W'(ax0) - D_W'(bx0_reg);
            e_ry0_reg <= D_W'(ay0) - D_W'(by0_reg);
            e_rx1_reg <= D_W'(ax1) - D_W'(bx0_reg);
            e_ry1_reg <= D_W'(ay1) - D_W'(by0_reg);
            m_idx_reg <= e_idx_reg;
            m_box_reg <= e_box_reg;
            m_p1a_reg <= e_qx0_reg * e_day_reg;
            m_p1b_reg <= e_qy0_reg * e_dax_reg;
            m_p2a_reg <= e_qx1_reg * e_day_reg;
            m_p2b_reg <= e_qy1_reg * e_dax_reg;
            m_p3a_reg <= e_rx0_reg * dby_reg;
            m_p3b_reg <= e_ry0_reg * dbx_reg;
            m_p4a_reg <= e_rx1_reg * dby_reg;
            m_p4b_reg <= e_ry1_reg * dbx_reg;
            h_idx_reg <= m_idx_reg;
            h_hit_reg <= m_box_reg && opposite(s1, s2) && opposite(s3, s4);
        end
        if (take_hit)
        begin
            pend_idx_reg <= h_idx_reg;
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_hit_reg    <= out_hit_next;
            out_idx_reg    <= out_idx_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign hit        = out_hit_reg;
    assign edge_index = out_idx_reg;
    assign last       = out_last_reg;

`include "polygon_segment_crossing_test_top_macros.svh"

    `PSCT_ASSERT_SAME(a_idle_pipe_empty, state_reg == ST_IDLE,
                      pipe_empty && !pend_valid_reg, "edge pipeline busy while idle")
    `PSCT_ASSERT_SAME(a_pend_counted, pend_valid_reg, hit_cnt_reg != '0,
                      "held hit without a count")
    `PSCT_ASSERT_SAME(a_nonfinal_pend, out_valid_reg && !out_last_reg,
                      pend_valid_reg && out_hit_reg, "non-final item without a held hit")
    `PSCT_ASSERT_SAME(a_count_range, 1'b1, vcount_reg <= CNT_W'(MAX_VERTS),
                      "vertex count beyond store depth")
    `PSCT_ASSERT_NEXT(a_finish_last, finish_go,
                      (state_reg == ST_IDLE) && out_valid_reg && out_last_reg,
                      "test ended without a final item")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon segment crossing test bench
// Builds polygons with clear and append items, then tests segments against
// them. Each accepted item is predicted on the spot and the result items are
// checked in order, with random gaps on the input side and random stalls on
// the output side.
// ----------------------------------------------------------------------------

module testbench;
    import psct_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RUN_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_ITEMS = 270;

    typedef struct {
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] x0;
        logic signed [COORD_BITS-1:0] y0;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
    } seg_item_t;

    typedef struct {
        logic              status;
        logic              hit;
        logic [EDGE_W-1:0] edge_idx;
        logic              last;
    } crossing_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [1:0]                   cmd = CMD_CLEAR;
    logic signed [COORD_BITS-1:0] seg_x0 = '0;
    logic signed [COORD_BITS-1:0] seg_y0 = '0;
    logic signed [COORD_BITS-1:0] seg_x1 = '0;
    logic signed [COORD_BITS-1:0] seg_y1 = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         status;
    logic                         hit;
    logic [EDGE_W-1:0]            edge_index;
    logic                         last;

    seg_item_t        pending_items[$];
    crossing_result_t expected_results[$];
    seg_item_t        driven_item;

    logic signed [COORD_BITS-1:0] poly_x[MAX_VERTS];
    logic signed [COORD_BITS-1:0] poly_y[MAX_VERTS];
    int poly_count = 0;

    int  items_taken = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    wire calm = (items_taken >= 90) && (items_taken < 170);

    polygon_segment_crossing_test_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .seg_x0     (seg_x0),
        .seg_y0     (seg_y0),
        .seg_x1     (seg_x1),
        .seg_y1     (seg_y1),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .hit        (hit),
        .edge_index (edge_index),
        .last       (last)
    );

    always #6 clk = ~clk;

    function automatic int side_sign(longint px, longint py, longint ex, longint ey,
                                     longint qx, longint qy);
        longint v;
        v = (qx - px) * (ey - py) - (qy - py) * (ex - px);
        if (v > 0)
            return 1;
        if (v < 0)
            return -1;
        return 0;
    endfunction

    function automatic bit spans_apart(longint a0, longint a1, longint b0, longint b1);
        longint alo, ahi, blo, bhi;
        alo = (a0 < a1) ? a0 : a1;
        ahi = (a0 < a1) ? a1 : a0;
        blo = (b0 < b1) ? b0 : b1;
        bhi = (b0 < b1) ? b1 : b0;
        return (blo > ahi) || (bhi < alo);
    endfunction

    function automatic bit edge_crossed(longint ax0, longint ay0, longint ax1, longint ay1,
                                        longint bx0, longint by0, longint bx1, longint by1);
        if (spans_apart(ax0, ax1, bx0, bx1) || spans_apart(ay0, ay1, by0, by1))
            return 1'b0;
        if (side_sign(ax0, ay0, ax1, ay1, bx0, by0) *
            side_sign(ax0, ay0, ax1, ay1, bx1, by1) >= 0)
            return 1'b0;
        if (side_sign(bx0, by0, bx1, by1, ax0, ay0) *
            side_sign(bx0, by0, bx1, by1, ax1, ay1) >= 0)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic apply_to_polygon(seg_item_t it);
        int               crossed[$];
        int               nx;
        crossing_result_t r;
        r = '{status: 1'b0, hit: 1'b0, edge_idx: '0, last: 1'b1};
        case (it.op)
            CMD_CLEAR:
            begin
                poly_count = 0;
                expected_results.push_back(r);
            end
            CMD_APPEND:
            begin
                if (poly_count >= MAX_VERTS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    poly_x[poly_count] = it.x0;
                    poly_y[poly_count] = it.y0;
                    poly_count++;
                end
                expected_results.push_back(r);
            end
            CMD_TEST:
            begin
                for (int k = 0; k < poly_count; k++)
                begin
                    nx = (k + 1 < poly_count) ? k + 1 : 0;
                    if (edge_crossed(poly_x[k], poly_y[k], poly_x[nx], poly_y[nx],
                                     it.x0, it.y0, it.x1, it.y1) &&
                        crossed.size() < RESULT_LIMIT)
                        crossed.push_back(k);
                end
                if (crossed.size() == 0)
                begin
                    expected_results.push_back(r);
                end
                else
                begin
                    foreach (crossed[i])
                    begin
                        r.hit = 1'b1;
                        r.edge_idx = EDGE_W'(crossed[i]);
                        r.last = (i == crossed.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default:
            begin
                expected_results.push_back(r);
            end
        endcase
    endtask

    // Input side: a new item is offered only once the previous one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_CLEAR;
            seg_x0 <= '0;
            seg_y0 <= '0;
            seg_x1 <= '0;
            seg_y1 <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_to_polygon(driven_item);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 6))
                begin
                    driven_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    cmd <= driven_item.op;
                    seg_x0 <= driven_item.x0;
                    seg_y0 <= driven_item.y0;
                    seg_x1 <= driven_item.x1;
                    seg_y1 <= driven_item.y1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each taken result item against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        crossing_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected result item: status %0d hit %0d edge %0d last %0d",
                                 status, hit, edge_index, last);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || hit !== want.hit ||
                        edge_index !== want.edge_idx || last !== want.last)
                    begin
                        if (error_count < 10)
                            $display("mismatch: expected status %0d hit %0d edge %0d last %0d, got status %0d hit %0d edge %0d last %0d",
                                     want.status, want.hit, want.edge_idx, want.last,
                                     status, hit, edge_index, last);
                        error_count++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 6);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] op, int x0, int y0, int x1, int y1);
        seg_item_t it;
        it.op = op;
        it.x0 = COORD_BITS'(x0);
        it.y0 = COORD_BITS'(y0);
        it.x1 = COORD_BITS'(x1);
        it.y1 = COORD_BITS'(y1);
        pending_items.push_back(it);
    endtask

    // A spread of zero means the full coordinate range.
    function automatic int rand_coord(int spread);
        if (spread == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    initial
    begin
        int counted;
        int spread;
        int shape;
        int nverts;
        int ntests;
        int ylevel;

        add_item(CMD_TEST, -32768, -32768, 32767, 32767);
        add_item(CMD_SPARE, 32767, -32768, -1, 0);
        add_item(CMD_APPEND, -32768, -32768, 0, 0);
        add_item(CMD_TEST, -32768, 32767, 32767, -32768);
        add_item(CMD_APPEND, 32767, 32767, -1, -1);
        add_item(CMD_TEST, -32768, 32767, 32767, -32768);
        add_item(CMD_TEST, -100, -100, 100, 100);
        add_item(CMD_TEST, 0, 0, 1000, -1000);
        add_item(CMD_CLEAR, -1, -1, -1, -1);
        add_item(CMD_APPEND, -100, -100, 0, 0);
        add_item(CMD_APPEND, 100, -100, 0, 0);
        add_item(CMD_APPEND, 100, 100, 0, 0);
        add_item(CMD_APPEND, -100, 100, 0, 0);
        add_item(CMD_TEST, -200, 0, 200, 0);
        add_item(CMD_TEST, -200, -200, 200, 200);
        add_item(CMD_TEST, 300, 300, 400, 450);
        add_item(CMD_TEST, 100, -300, 100, 300);
        add_item(CMD_CLEAR, 0, 0, 0, 0);
        add_item(CMD_TEST, -200, 0, 200, 0);

        // Mostly whole polygons followed by tests, with some noise mixed in.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                add_item(CMD_SPARE, rand_coord(0), rand_coord(0), rand_coord(0),
                         rand_coord(0));
            if ($urandom_range(0, 5) != 0)
            begin
                add_item(CMD_CLEAR, rand_coord(0), rand_coord(0), rand_coord(0),
                         rand_coord(0));
                counted++;
            end
            shape = $urandom_range(0, 3);
            spread = (shape == 0) ? 0 : (shape == 1) ? 400 : 4;
            case ($urandom_range(0, 9))
                0: nverts = $urandom_range(0, 2);
                1: nverts = $urandom_range(30, 36);
                default: nverts = $urandom_range(3, 10);
            endcase
            if (shape == 3)
                nverts = 2 * $urandom_range(2, 17);
            for (int k = 0; k < nverts; k++)
            begin
                if (shape == 3)
                    add_item(CMD_APPEND, -30000 + k * 1500, (k % 2 == 0) ? 500 : -500,
                             rand_coord(0), rand_coord(0));
                else
                    add_item(CMD_APPEND, rand_coord(spread), rand_coord(spread),
                             rand_coord(0), rand_coord(0));
            end
            ntests = $urandom_range(1, 5);
            for (int t = 0; t < ntests; t++)
            begin
                if (shape == 3 && t == 0)
                begin
                    ylevel = $urandom_range(0, 798) - 399;
                    add_item(CMD_TEST, -32000, ylevel, 32767, ylevel);
                end
                else if (shape == 3)
                    add_item(CMD_TEST, rand_coord(0), rand_coord(600), rand_coord(0),
                             rand_coord(600));
                else
                    add_item(CMD_TEST, rand_coord(spread), rand_coord(spread),
                             rand_coord(spread), rand_coord(spread));
            end
            counted += nverts + ntests;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
